>>> rtl/core/cna_pkg.sv
// ----------------------------------------------------------------------------
// cna_pkg: shared types and constants of the complex number alu
// word formats, opcodes, status codes and the pipeline stage record
// ----------------------------------------------------------------------------
package cna_pkg;

    // operand format, signed fixed point
    localparam int DW = 16;
    localparam int FB = 8;

    // derived widths
    localparam int PW = 2 * DW;        // product width
    localparam int SW = PW + 1;        // sum of two products
    localparam int NW = SW + FB;       // divider partial remainder
    localparam int QW = DW + 1;        // quotient bits, one divider step each
    localparam int CW = NW + QW;       // divider compare width
    localparam int OW = SW + DW + 1;   // quotient overflow compare width
    localparam int OS = DW + 1 - FB;   // overflow shift of the denominator

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    // one word in flight through the divider and square root steps
    typedef struct packed {
        logic [2:0]    op;
        logic [DW-1:0] e0;
        logic [DW-1:0] e1;
        logic [DW-1:0] e2;
        logic [DW-1:0] e3;
        logic          e_sat;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [PW-1:0] den;
        logic [NW-1:0] rem_re;
        logic [NW-1:0] rem_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
        logic [PW-1:0] sx_a;
        logic [PW-1:0] sx_b;
        logic [PW-1:0] sr_a;
        logic [PW-1:0] sr_b;
    } t_stage;

    // result word
    typedef struct packed {
        logic [DW-1:0] first_re;
        logic [DW-1:0] first_im;
        logic [DW-1:0] second_re;
        logic [DW-1:0] second_im;
        logic [1:0]    status;
    } t_result;

endpackage

>>> rtl/core/cna_in_if.sv
// ----------------------------------------------------------------------------
// cna_in_if: operand channel of the complex number alu
// valid/ready handshake carrying an opcode and two complex operands
// ----------------------------------------------------------------------------
interface cna_in_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      opcode;
    logic signed [cna_pkg::DW-1:0]   a_re;
    logic signed [cna_pkg::DW-1:0]   a_im;
    logic signed [cna_pkg::DW-1:0]   b_re;
    logic signed [cna_pkg::DW-1:0]   b_im;

    modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

>>> rtl/core/cna_out_if.sv
// ----------------------------------------------------------------------------
// cna_out_if: result channel of the complex number alu
// valid/ready handshake carrying four values and a status
// ----------------------------------------------------------------------------
interface cna_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [cna_pkg::DW-1:0]   first_re;
    logic signed [cna_pkg::DW-1:0]   first_im;
    logic signed [cna_pkg::DW-1:0]   second_re;
    logic signed [cna_pkg::DW-1:0]   second_im;
    logic [1:0]                      status;

    modport source (output valid, first_re, first_im, second_re, second_im, status,
                    input ready);
    modport sink   (input valid, first_re, first_im, second_re, second_im, status,
                    output ready);
endinterface

>>> rtl/core/complex_number_alu_core.sv
// ----------------------------------------------------------------------------
// complex_number_alu_core: pipelined complex arithmetic unit
// add, subtract, multiply, divide, conjugate and modulus on signed fixed point
// ----------------------------------------------------------------------------
// path: stage a, the divider and square root steps, then the output register
// throughput: one word per cycle unless the output stalls; the restoring divider
//   sets depth: one quotient bit per stage (17 stages, square root rides along)
// a full stage waits while the next cannot take its word; bubbles are squeezed
// reset: synchronous active low, clears all valid bits; the pipe comes up empty
module complex_number_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cna_in_if.sink      i_in,
    cna_out_if.source   o_out
);

    localparam int DW = cna_pkg::DW;
    localparam int FB = cna_pkg::FB;
    localparam int PW = cna_pkg::PW;
    localparam int SW = cna_pkg::SW;
    localparam int NW = cna_pkg::NW;
    localparam int QW = cna_pkg::QW;
    localparam int CW = cna_pkg::CW;
    localparam int OW = cna_pkg::OW;
    localparam int OS = cna_pkg::OS;

    localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    // clamp a signed sum, returns {sat, value}
    function automatic logic [DW:0] f_sclamp(input logic [SW-1:0] v);
        logic same;
        same = (&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]);
        if (same) begin
            return {1'b0, v[DW-1:0]};
        end
        return {1'b1, (v[SW-1] ? VMIN : VMAX)};
    endfunction

    // clamp a sign and magnitude, returns {sat, value}
    function automatic logic [DW:0] f_mclamp(input logic neg, input logic [SW-1:0] m);
        logic [DW-1:0] nv;
        nv = (~m[DW-1:0]) + DW'(1);
        if (neg) begin
            if ((|m[SW-1:DW]) || (m[DW-1] && (|m[DW-2:0]))) begin
                return {1'b1, VMIN};
            end
            return {1'b0, nv};
        end
        if (|m[SW-1:DW-1]) begin
            return {1'b1, VMAX};
        end
        return {1'b0, m[DW-1:0]};
    endfunction

    // one divider bit and, for k below DW, one square root step
    function automatic cna_pkg::t_stage f_step(input cna_pkg::t_stage s, input int k);
        cna_pkg::t_stage r;
        logic [CW-1:0]   c;
        logic [PW-1:0]   b;
        logic [PW-1:0]   t;
        int              i;
        r = s;
        i = QW - 1 - k;
        if (s.op == cna_pkg::OP_DIV) begin
            c = CW'(s.den) << i;
            if (CW'(s.rem_re) >= c) begin
                r.rem_re  = s.rem_re - c[NW-1:0];
                r.q_re[i] = 1'b1;
            end
            if (CW'(s.rem_im) >= c) begin
                r.rem_im  = s.rem_im - c[NW-1:0];
                r.q_im[i] = 1'b1;
            end
        end
        if (k < DW) begin
            b = PW'(1) << (PW - 2 - 2 * k);
            t = s.sr_a + b;
            if (s.sx_a >= t) begin
                r.sx_a = s.sx_a - t;
                r.sr_a = (s.sr_a >> 1) + b;
            end else begin
                r.sr_a = s.sr_a >> 1;
            end
            t = s.sr_b + b;
            if (s.sx_b >= t) begin
                r.sx_b = s.sx_b - t;
                r.sr_b = (s.sr_b >> 1) + b;
            end else begin
                r.sr_b = s.sr_b >> 1;
            end
        end
        return r;
    endfunction

    // stage enables, back to front
    logic          en_a;
    logic          en_o;
    logic [QW:0]   en_p;

    logic          r_va;
    logic [QW:0]   r_pv;
    logic          r_vo;

    always_comb begin
        en_o     = !r_vo || o_out.ready;
        en_p[QW] = !r_pv[QW] || en_o;
        for (int k = QW - 1; k >= 0; k--) begin
            en_p[k] = !r_pv[k] || en_p[k+1];
        end
        en_a = !r_va || en_p[0];
    end

    assign i_in.ready = en_a;

    // stage a: operands and products
    logic [2:0]           r_op;
    logic signed [DW-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [PW-1:0] r_p_ar2, r_p_ai2, r_p_br2, r_p_bi2;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_op    <= i_in.opcode;
            r_ar    <= i_in.a_re;
            r_ai    <= i_in.a_im;
            r_br    <= i_in.b_re;
            r_bi    <= i_in.b_im;
            r_p_rr  <= PW'(i_in.a_re) * PW'(i_in.b_re);
            r_p_ii  <= PW'(i_in.a_im) * PW'(i_in.b_im);
            r_p_ri  <= PW'(i_in.a_re) * PW'(i_in.b_im);
            r_p_ir  <= PW'(i_in.a_im) * PW'(i_in.b_re);
            r_p_ar2 <= PW'(i_in.a_re) * PW'(i_in.a_re);
            r_p_ai2 <= PW'(i_in.a_im) * PW'(i_in.a_im);
            r_p_br2 <= PW'(i_in.b_re) * PW'(i_in.b_re);
            r_p_bi2 <= PW'(i_in.b_im) * PW'(i_in.b_im);
        end
    end

    // stage b: sums, signs, denominator, simple results
    cna_pkg::t_stage      n_b;
    logic signed [SW-1:0] s_re, s_im;
    logic [SW-1:0]        m_re, m_im;
    logic [DW:0]          c0, c1, c2;

    always_comb begin
        n_b = '0;
        n_b.op = r_op;
        if (r_op == cna_pkg::OP_MUL) begin
            s_re = SW'(r_p_rr) - SW'(r_p_ii);
            s_im = SW'(r_p_ri) + SW'(r_p_ir);
        end else begin
            s_re = SW'(r_p_rr) + SW'(r_p_ii);
            s_im = SW'(r_p_ir) - SW'(r_p_ri);
        end
        m_re = s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
        m_im = s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
        n_b.neg_re = s_re[SW-1];
        n_b.neg_im = s_im[SW-1];
        n_b.rem_re = {m_re, {FB{1'b0}}};
        n_b.rem_im = {m_im, {FB{1'b0}}};
        n_b.den    = r_p_br2[PW-1:0] + r_p_bi2[PW-1:0];
        n_b.dz     = (n_b.den == '0);
        n_b.ovf_re = OW'(m_re) >= (OW'(n_b.den) << OS);
        n_b.ovf_im = OW'(m_im) >= (OW'(n_b.den) << OS);
        n_b.sx_a   = r_p_ar2[PW-1:0] + r_p_ai2[PW-1:0];
        n_b.sx_b   = n_b.den;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        unique case (r_op)
            cna_pkg::OP_ADD: begin
                c0 = f_sclamp(SW'(r_ar) + SW'(r_br));
                c1 = f_sclamp(SW'(r_ai) + SW'(r_bi));
            end
            cna_pkg::OP_SUB: begin
                c0 = f_sclamp(SW'(r_ar) - SW'(r_br));
                c1 = f_sclamp(SW'(r_ai) - SW'(r_bi));
            end
            cna_pkg::OP_CONJ: begin
                c1 = f_sclamp(-SW'(r_ai));
                c2 = f_sclamp(-SW'(r_bi));
                n_b.e2 = r_br;
                c0 = {1'b0, r_ar};
            end
            default: begin
            end
        endcase
        n_b.e0    = c0[DW-1:0];
        n_b.e1    = c1[DW-1:0];
        n_b.e3    = c2[DW-1:0];
        n_b.e_sat = c0[DW] | c1[DW] | c2[DW];
    end

    // divider and square root steps
    cna_pkg::t_stage r_pipe [0:QW];

    always_ff @(posedge i_clk) begin
        if (en_p[0]) begin
            r_pipe[0] <= n_b;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (en_p[k+1]) begin
                r_pipe[k+1] <= f_step(r_pipe[k], k);
            end
        end
    end

    // final stage: clamp and select
    cna_pkg::t_stage  s_f;
    cna_pkg::t_result n_res;
    cna_pkg::t_result r_res;
    logic [DW:0]      f0, f1;

    always_comb begin
        s_f   = r_pipe[QW];
        n_res = '0;
        f0    = '0;
        f1    = '0;
        unique case (s_f.op)
            cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_CONJ: begin
                n_res.first_re  = s_f.e0;
                n_res.first_im  = s_f.e1;
                n_res.second_re = s_f.e2;
                n_res.second_im = s_f.e3;
                n_res.status    = s_f.e_sat ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
            end
            cna_pkg::OP_MUL: begin
                f0 = f_mclamp(s_f.neg_re, SW'(s_f.rem_re[NW-1:2*FB]));
                f1 = f_mclamp(s_f.neg_im, SW'(s_f.rem_im[NW-1:2*FB]));
                n_res.first_re = f0[DW-1:0];
                n_res.first_im = f1[DW-1:0];
                n_res.status   = (f0[DW] | f1[DW]) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
            end
            cna_pkg::OP_DIV: begin
                if (s_f.dz) begin
                    n_res.status = cna_pkg::ST_DZ;
                end else begin
                    f0 = s_f.ovf_re ? {1'b1, (s_f.neg_re ? VMIN : VMAX)}
                                    : f_mclamp(s_f.neg_re, SW'(s_f.q_re));
                    f1 = s_f.ovf_im ? {1'b1, (s_f.neg_im ? VMIN : VMAX)}
                                    : f_mclamp(s_f.neg_im, SW'(s_f.q_im));
                    n_res.first_re = f0[DW-1:0];
                    n_res.first_im = f1[DW-1:0];
                    n_res.status   = (f0[DW] | f1[DW]) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
                end
            end
            cna_pkg::OP_MOD: begin
                f0 = f_mclamp(1'b0, SW'(s_f.sr_a));
                f1 = f_mclamp(1'b0, SW'(s_f.sr_b));
                n_res.first_re  = f0[DW-1:0];
                n_res.second_re = f1[DW-1:0];
                n_res.status    = (f0[DW] | f1[DW]) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_res <= n_res;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_pv <= '0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_in.valid;
            end
            if (en_p[0]) begin
                r_pv[0] <= r_va;
            end
            for (int k = 1; k <= QW; k++) begin
                if (en_p[k]) begin
                    r_pv[k] <= r_pv[k-1];
                end
            end
            if (en_o) begin
                r_vo <= r_pv[QW];
            end
        end
    end

    // result word
    assign o_out.valid     = r_vo;
    assign o_out.first_re  = r_res.first_re;
    assign o_out.first_im  = r_res.first_im;
    assign o_out.second_re = r_res.second_re;
    assign o_out.second_im = r_res.second_im;
    assign o_out.status    = r_res.status;

    // divide by zero gives an all-zero word
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == cna_pkg::ST_DZ) |->
        (o_out.first_re == '0 && o_out.first_im == '0 &&
         o_out.second_re == '0 && o_out.second_im == '0))
        else $error("divide by zero word carries nonzero values");

    // a stalled result stays in the output register
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !o_out.ready) |=> (r_vo && $stable(r_res)))
        else $error("stalled result word lost or changed");

    // input is refused only when the first stage holds a word
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_va && r_pv[0]))
        else $error("input refused with room in the pipe");

endmodule
